// File: hw/rtl/xst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xst_pkg: shared types, constants and helpers of the xml stream tokenizer
// event codes, error codes, parser phases and character classes
// ----------------------------------------------------------------------------
package xst_pkg;

  localparam int unsigned LineBitsDef   = 24;
  localparam int unsigned RefNameMaxDef = 5;
  localparam int unsigned MaxRes        = 5;
  localparam int unsigned ResIdxW       = $clog2(MaxRes);
  localparam int unsigned ResCntW       = $clog2(MaxRes + 1);
  localparam logic [24:0] CodeTop       = 25'h010FFFF;

  localparam logic [3:0] EvText       = 4'd0;
  localparam logic [3:0] EvTextEnd    = 4'd1;
  localparam logic [3:0] EvTagBase    = 4'd2;
  localparam logic [3:0] EvDoctype    = 4'd5;
  localparam logic [3:0] EvAttrName   = 4'd6;
  localparam logic [3:0] EvAttrValue  = 4'd7;
  localparam logic [3:0] EvHeaderDone = 4'd8;
  localparam logic [3:0] EvDeclDone   = 4'd9;
  localparam logic [3:0] EvEndSection = 4'd10;
  localparam logic [3:0] EvDtDone     = 4'd11;
  localparam logic [3:0] EvAttrDone   = 4'd12;
  localparam logic [3:0] EvError      = 4'd13;
  localparam logic [3:0] EvEof        = 4'd14;

  localparam logic [3:0] ErrBadRef    = 4'd0;
  localparam logic [3:0] ErrEof       = 4'd1;
  localparam logic [3:0] ErrEndGt     = 4'd2;
  localparam logic [3:0] ErrDtName    = 4'd3;
  localparam logic [3:0] ErrBangName  = 4'd4;
  localparam logic [3:0] ErrLtName    = 4'd5;
  localparam logic [3:0] ErrEq        = 4'd6;
  localparam logic [3:0] ErrQuote     = 4'd7;
  localparam logic [3:0] ErrDeclEnd   = 4'd8;
  localparam logic [3:0] ErrAttrSpace = 4'd9;
  localparam logic [3:0] ErrStrayGt   = 4'd10;
  localparam logic [3:0] ErrValue     = 4'd11;

  localparam logic [1:0] TagSection = 2'd0;
  localparam logic [1:0] TagDecl    = 2'd1;
  localparam logic [1:0] TagEnd     = 2'd2;
  localparam logic [1:0] TagBang    = 2'd3;

  // named reference matcher codes
  localparam logic [3:0] RmLt   = 4'd2;
  localparam logic [3:0] RmGt   = 4'd4;
  localparam logic [3:0] RmAmp  = 4'd7;
  localparam logic [3:0] RmApos = 4'd10;
  localparam logic [3:0] RmQuot = 4'd14;
  localparam logic [3:0] RmNone = 4'd15;

  typedef enum logic [17:0] {
    PH_TEXT        = 18'h00001,
    PH_LT          = 18'h00002,
    PH_LT_MARK     = 18'h00004,
    PH_NAME        = 18'h00008,
    PH_GT_WAIT     = 18'h00010,
    PH_BANG_DASH   = 18'h00020,
    PH_COMMENT     = 18'h00040,
    PH_DT_SPACE    = 18'h00080,
    PH_DT_NAME     = 18'h00100,
    PH_DT_SKIP     = 18'h00200,
    PH_ATTR_SPACE  = 18'h00400,
    PH_ATTR_NAME   = 18'h00800,
    PH_EQ_SPACE    = 18'h01000,
    PH_QUOTE_SPACE = 18'h02000,
    PH_VALUE       = 18'h04000,
    PH_DECL_GT     = 18'h08000,
    PH_REF         = 18'h10000,
    PH_HALT        = 18'h20000
  } ph_e;

  typedef enum logic [4:0] {
    RS_START = 5'h01,
    RS_NAME  = 5'h02,
    RS_HASH  = 5'h04,
    RS_DEC   = 5'h08,
    RS_HEX   = 5'h10
  } rs_e;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  data;
    logic [3:0]  err;
    logic [23:0] line;
  } res_t;

  typedef struct packed {
    res_t [MaxRes-1:0]  r;
    logic [ResCntW-1:0] cnt;
  } batch_t;

  function automatic res_t mk_res(logic [3:0] kind, logic [7:0] data, logic [3:0] err,
                                  logic [23:0] line);
    res_t r;
    r.kind = kind;
    r.data = data;
    r.err  = err;
    r.line = line;
    return r;
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    logic [7:0] l;
    l = c | 8'h20;
    return (l >= "a") && (l <= "z");
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic name_first(logic [7:0] c);
    return (c == ":") || (c == "_") || is_letter(c);
  endfunction

  function automatic logic name_char(logic [7:0] c);
    return name_first(c) || is_digit(c) || (c == "-") || (c == ".");
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == " ") || (c == 8'h09) || (c == 8'h0D);
  endfunction

  // letters of the doctype keyword after its first one
  function automatic logic [7:0] dt_char(logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd1:    r = "O";
      3'd2:    r = "C";
      3'd3:    r = "T";
      3'd4:    r = "Y";
      3'd5:    r = "P";
      3'd6:    r = "E";
      default: r = "D";
    endcase
    return r;
  endfunction

  function automatic logic [3:0] ref_next(logic [3:0] m, logic [7:0] c);
    logic [3:0] r;
    r = RmNone;
    case (m)
      4'd0: begin
        if (c == "l") r = 4'd1;
        else if (c == "g") r = 4'd3;
        else if (c == "a") r = 4'd5;
        else if (c == "q") r = 4'd11;
      end
      4'd1, 4'd3: if (c == "t") r = m + 4'd1;
      4'd5: begin
        if (c == "m") r = 4'd6;
        else if (c == "p") r = 4'd8;
      end
      4'd6:  if (c == "p") r = 4'd7;
      4'd8:  if (c == "o") r = 4'd9;
      4'd9:  if (c == "s") r = 4'd10;
      4'd11: if (c == "u") r = 4'd12;
      4'd12: if (c == "o") r = 4'd13;
      4'd13: if (c == "t") r = 4'd14;
      default: r = RmNone;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/xst_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xst_step: parser state and single-pass step logic
// turns one registered input byte into a batch of events and the next state
// ----------------------------------------------------------------------------
module xst_step #(
  parameter int unsigned LINE_BITS    = xst_pkg::LineBitsDef,
  parameter int unsigned REF_NAME_MAX = xst_pkg::RefNameMaxDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           fire_i,
  input  wire logic [7:0]     data_byte_i,
  input  wire logic           end_of_input_i,
  output xst_pkg::batch_t     batch_o
);
  import xst_pkg::*;

  localparam logic [LINE_BITS-1:0] LineTop = {LINE_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0] LineOne = LINE_BITS'(1);
  localparam logic [20:0]          RefMax  = 21'(REF_NAME_MAX);

  ph_e                  ph_q, ph_d;
  rs_e                  rs_q, rs_d;
  logic                 attr_q, attr_d;
  logic [LINE_BITS-1:0] lc_q, lc_d, tl_q, tl_d;
  logic [20:0]          cc_q, cc_d;
  logic [3:0]           rm_q, rm_d;
  logic [2:0]           dc_q, dc_d;
  logic [1:0]           cm_q, cm_d;
  logic [1:0]           tk_q, tk_d;
  logic                 ep_q, ep_d, tp_q, tp_d;
  logic [2:0]           dm_q, dm_d;

  always_comb begin
    logic [7:0]           c;
    logic                 eof;
    logic                 skip;
    logic                 fl;
    logic [3:0]           fc;
    logic                 fin;
    logic [20:0]          fv;
    logic [3:0]           kd;
    logic [24:0]          v;
    logic [3:0]           dig;
    logic [LINE_BITS+23:0] lw;
    logic [ResCntW-1:0]   n;
    eof  = end_of_input_i;
    c    = eof ? 8'h00 : data_byte_i;
    ph_d = ph_q;  rs_d = rs_q;  attr_d = attr_q;
    lc_d = lc_q;  tl_d = tl_q;  cc_d = cc_q;  rm_d = rm_q;  dc_d = dc_q;
    cm_d = cm_q;  tk_d = tk_q;  ep_d = ep_q;  tp_d = tp_q;  dm_d = dm_q;
    batch_o = '0;
    n    = '0;
    skip = 1'b0;
    fl   = 1'b0;
    fc   = ErrBadRef;
    fin  = 1'b0;
    fv   = '0;
    v    = '0;
    dig  = '0;
    lw   = '0;
    if (ph_q == PH_HALT) begin
      if (eof) begin
        lw = {24'b0, tl_d};
        batch_o.r[n] = mk_res(EvEof, 8'h00, 4'd0, lw[23:0]);
        n = n + ResCntW'(1);
      end
    end else begin
      // a name ends: the byte is taken again by the phase that follows
      if (!name_char(c)) begin
        if (ph_d == PH_NAME) begin
          if (tk_d == TagEnd) begin
            ep_d = 1'b0;
            ph_d = PH_GT_WAIT;
          end else if (tk_d == TagBang) begin
            ph_d = (dm_d == 3'd7) ? PH_DT_SPACE : PH_DT_SKIP;
          end else begin
            ph_d = PH_ATTR_SPACE;
          end
        end else if (ph_d == PH_ATTR_NAME) begin
          ph_d = PH_EQ_SPACE;
        end else if (ph_d == PH_DT_NAME) begin
          ph_d = PH_DT_SKIP;
        end
      end
      if (ph_d == PH_DT_SPACE || ph_d == PH_ATTR_SPACE ||
          ph_d == PH_EQ_SPACE || ph_d == PH_QUOTE_SPACE) begin
        if (is_blank(c)) begin
          skip = 1'b1;
        end else if (c == 8'h0A) begin
          skip = 1'b1;
          if (lc_d != LineTop) lc_d = lc_d + LineOne;
        end
      end
      lw = {24'b0, tl_d};
      if (!skip) begin
        unique case (ph_d)
          PH_REF: begin
            if (eof) begin
              fl = 1'b1;
            end else begin
              unique case (rs_d)
                RS_START: begin
                  if (c == "#") begin
                    cc_d = '0;
                    dc_d = '0;
                    rs_d = RS_HASH;
                  end else if (c >= "a" && c <= "z") begin
                    rm_d = ref_next(4'd0, c);
                    cc_d = 21'd1;
                    rs_d = RS_NAME;
                  end else begin
                    fl = 1'b1;
                  end
                end
                RS_NAME: begin
                  if (cc_d >= RefMax) begin
                    fl = 1'b1;
                  end else if (c >= "a" && c <= "z") begin
                    rm_d = ref_next(rm_d, c);
                    cc_d = cc_d + 21'd1;
                  end else if (c == ";") begin
                    fin = 1'b1;
                    case (rm_d)
                      RmLt:    fv = 21'h3C;
                      RmGt:    fv = 21'h3E;
                      RmAmp:   fv = 21'h26;
                      RmApos:  fv = 21'h27;
                      RmQuot:  fv = 21'h22;
                      default: begin
                        fin = 1'b0;
                        fl  = 1'b1;
                      end
                    endcase
                  end else begin
                    fl = 1'b1;
                  end
                end
                RS_HASH: begin
                  if (c == "x" || c == "X") begin
                    cc_d = '0;
                    dc_d = '0;
                    rs_d = RS_HEX;
                  end else if (is_digit(c)) begin
                    cc_d = 21'(c - "0");
                    dc_d = 3'd1;
                    rs_d = RS_DEC;
                  end else begin
                    fl = 1'b1;
                  end
                end
                default: begin
                  if (c == ";") begin
                    if (dc_d != 3'd0) begin
                      fin = 1'b1;
                      fv  = cc_d;
                    end else begin
                      fl = 1'b1;
                    end
                  end else if (is_digit(c) ||
                               (rs_d == RS_HEX && (c | 8'h20) >= "a" && (c | 8'h20) <= "f"))
                  begin
                    dig = is_digit(c) ? 4'(c - "0") : 4'((c | 8'h20) - "a" + 8'd10);
                    if (rs_d == RS_HEX) v = {cc_d, 4'b0};
                    else v = {1'b0, cc_d, 3'b0} + {3'b0, cc_d, 1'b0};
                    v = v + {21'b0, dig};
                    if (v > CodeTop) begin
                      fl = 1'b1;
                    end else begin
                      cc_d = v[20:0];
                      if (dc_d < 3'd7) dc_d = dc_d + 3'd1;
                    end
                  end else begin
                    fl = 1'b1;
                  end
                end
              endcase
            end
          end
          PH_TEXT: begin
            if (eof || c == "<") begin
              if (tp_d) begin
                batch_o.r[n] = mk_res(EvTextEnd, 8'h00, 4'd0, lw[23:0]);
                n = n + ResCntW'(1);
                tp_d = 1'b0;
                tl_d = lc_d;
              end
              if (!eof) ph_d = PH_LT;
            end else if (c == "&") begin
              attr_d = 1'b0;
              rs_d   = RS_START;
              ph_d   = PH_REF;
            end else if (c == ">") begin
              fl = 1'b1;
              fc = ErrStrayGt;
            end else begin
              if (c == 8'h0A && lc_d != LineTop) lc_d = lc_d + LineOne;
              batch_o.r[n] = mk_res(EvText, c, 4'd0, lw[23:0]);
              n = n + ResCntW'(1);
              tp_d = 1'b1;
            end
          end
          PH_LT: begin
            if (c == 8'h00) begin
              fl = 1'b1;
              fc = ErrEof;
            end else if (name_first(c)) begin
              tk_d = TagSection;
              batch_o.r[n] = mk_res(EvTagBase, c, 4'd0, lw[23:0]);
              n = n + ResCntW'(1);
              ph_d = PH_NAME;
            end else if (c == "/") begin
              tk_d = TagEnd;
              ph_d = PH_LT_MARK;
            end else if (c == "?") begin
              tk_d = TagDecl;
              ph_d = PH_LT_MARK;
            end else if (c == "!") begin
              tk_d = TagBang;
              ph_d = PH_LT_MARK;
            end else begin
              fl = 1'b1;
              fc = ErrLtName;
            end
          end
          PH_LT_MARK: begin
            if (name_first(c)) begin
              batch_o.r[n] = mk_res(EvTagBase + {2'b0, tk_d}, c, 4'd0, lw[23:0]);
              n = n + ResCntW'(1);
              dm_d = (c == "D") ? 3'd1 : 3'd0;
              ph_d = PH_NAME;
            end else if (tk_d == TagBang && c == "-") begin
              ph_d = PH_BANG_DASH;
            end else begin
              fl = 1'b1;
              fc = ErrBangName;
            end
          end
          PH_NAME: begin
            batch_o.r[n] = mk_res(EvTagBase + {2'b0, tk_d}, c, 4'd0, lw[23:0]);
            n = n + ResCntW'(1);
            if (tk_d == TagBang) begin
              dm_d = (dm_d != 3'd0 && dm_d < 3'd7 && c == dt_char(dm_d)) ?
                     dm_d + 3'd1 : 3'd0;
            end
          end
          PH_GT_WAIT: begin
            if (c == ">") begin
              if (ep_d) begin
                batch_o.r[n] = mk_res(EvHeaderDone, 8'h00, 4'd0, lw[23:0]);
                n = n + ResCntW'(1);
                tl_d = lc_d;
                lw = {24'b0, tl_d};
              end
              batch_o.r[n] = mk_res(EvEndSection, 8'h00, 4'd0, lw[23:0]);
              n = n + ResCntW'(1);
              tl_d = lc_d;
              ep_d = 1'b0;
              ph_d = PH_TEXT;
            end else begin
              fl = 1'b1;
              fc = ErrEndGt;
            end
          end
          PH_BANG_DASH: begin
            if (c == "-") begin
              cm_d = 2'd0;
              ph_d = PH_COMMENT;
            end else begin
              fl = 1'b1;
              fc = ErrBangName;
            end
          end
          PH_COMMENT: begin
            if (eof) begin
              fl = 1'b1;
              fc = ErrEof;
            end else if (c == "-") begin
              cm_d = (cm_d < 2'd2) ? cm_d + 2'd1 : 2'd2;
            end else if (c == ">" && cm_d == 2'd2) begin
              cm_d = 2'd0;
              ph_d = PH_TEXT;
            end else begin
              if (c == 8'h0A && lc_d != LineTop) lc_d = lc_d + LineOne;
              cm_d = 2'd0;
            end
          end
          PH_DT_SPACE: begin
            if (name_first(c)) begin
              batch_o.r[n] = mk_res(EvDoctype, c, 4'd0, lw[23:0]);
              n = n + ResCntW'(1);
              ph_d = PH_DT_NAME;
            end else begin
              fl = 1'b1;
              fc = ErrDtName;
            end
          end
          PH_DT_NAME: begin
            batch_o.r[n] = mk_res(EvDoctype, c, 4'd0, lw[23:0]);
            n = n + ResCntW'(1);
          end
          PH_DT_SKIP: begin
            if (eof) begin
              fl = 1'b1;
              fc = ErrEof;
            end else if (c == 8'h0A) begin
              if (lc_d != LineTop) lc_d = lc_d + LineOne;
            end else if (c == ">") begin
              batch_o.r[n] = mk_res(EvDtDone, 8'h00, 4'd0, lw[23:0]);
              n = n + ResCntW'(1);
              tl_d = lc_d;
              ph_d = PH_TEXT;
            end
          end
          PH_ATTR_SPACE: begin
            if (name_first(c)) begin
              batch_o.r[n] = mk_res(EvAttrName, c, 4'd0, lw[23:0]);
              n = n + ResCntW'(1);
              ph_d = PH_ATTR_NAME;
            end else if (tk_d == TagDecl) begin
              if (c == "?") begin
                ph_d = PH_DECL_GT;
              end else begin
                fl = 1'b1;
                fc = ErrDeclEnd;
              end
            end else if (c == "/") begin
              ep_d = 1'b1;
              ph_d = PH_GT_WAIT;
            end else if (c == ">") begin
              batch_o.r[n] = mk_res(EvHeaderDone, 8'h00, 4'd0, lw[23:0]);
              n = n + ResCntW'(1);
              tl_d = lc_d;
              ph_d = PH_TEXT;
            end else begin
              fl = 1'b1;
              fc = ErrAttrSpace;
            end
          end
          PH_ATTR_NAME: begin
            batch_o.r[n] = mk_res(EvAttrName, c, 4'd0, lw[23:0]);
            n = n + ResCntW'(1);
          end
          PH_EQ_SPACE: begin
            if (c == "=") begin
              ph_d = PH_QUOTE_SPACE;
            end else begin
              fl = 1'b1;
              fc = ErrEq;
            end
          end
          PH_QUOTE_SPACE: begin
            if (c == "\"") begin
              ph_d = PH_VALUE;
            end else begin
              fl = 1'b1;
              fc = ErrQuote;
            end
          end
          PH_VALUE: begin
            if (c == 8'h0A || c == 8'h00) begin
              fl = 1'b1;
              fc = ErrValue;
            end else if (c == "&") begin
              attr_d = 1'b1;
              rs_d   = RS_START;
              ph_d   = PH_REF;
            end else if (c == "\"") begin
              batch_o.r[n] = mk_res(EvAttrDone, 8'h00, 4'd0, lw[23:0]);
              n = n + ResCntW'(1);
              ph_d = PH_ATTR_SPACE;
            end else begin
              batch_o.r[n] = mk_res(EvAttrValue, c, 4'd0, lw[23:0]);
              n = n + ResCntW'(1);
            end
          end
          PH_DECL_GT: begin
            if (c == ">") begin
              batch_o.r[n] = mk_res(EvDeclDone, 8'h00, 4'd0, lw[23:0]);
              n = n + ResCntW'(1);
              tl_d = lc_d;
              ph_d = PH_TEXT;
            end else begin
              fl = 1'b1;
              fc = ErrDeclEnd;
            end
          end
          default: begin
          end
        endcase
      end
      // reference complete: utf-8 encode the code point
      if (fin) begin
        kd = attr_d ? EvAttrValue : EvText;
        if (fv < 21'h80) begin
          batch_o.r[n] = mk_res(kd, fv[7:0], 4'd0, lw[23:0]);
          n = n + ResCntW'(1);
        end else if (fv < 21'h800) begin
          batch_o.r[n] = mk_res(kd, {3'b110, fv[10:6]}, 4'd0, lw[23:0]);
          n = n + ResCntW'(1);
          batch_o.r[n] = mk_res(kd, {2'b10, fv[5:0]}, 4'd0, lw[23:0]);
          n = n + ResCntW'(1);
        end else if (fv < 21'h10000) begin
          batch_o.r[n] = mk_res(kd, {4'b1110, fv[15:12]}, 4'd0, lw[23:0]);
          n = n + ResCntW'(1);
          batch_o.r[n] = mk_res(kd, {2'b10, fv[11:6]}, 4'd0, lw[23:0]);
          n = n + ResCntW'(1);
          batch_o.r[n] = mk_res(kd, {2'b10, fv[5:0]}, 4'd0, lw[23:0]);
          n = n + ResCntW'(1);
        end else begin
          batch_o.r[n] = mk_res(kd, {5'b11110, fv[20:18]}, 4'd0, lw[23:0]);
          n = n + ResCntW'(1);
          batch_o.r[n] = mk_res(kd, {2'b10, fv[17:12]}, 4'd0, lw[23:0]);
          n = n + ResCntW'(1);
          batch_o.r[n] = mk_res(kd, {2'b10, fv[11:6]}, 4'd0, lw[23:0]);
          n = n + ResCntW'(1);
          batch_o.r[n] = mk_res(kd, {2'b10, fv[5:0]}, 4'd0, lw[23:0]);
          n = n + ResCntW'(1);
        end
        if (!attr_d) tp_d = 1'b1;
        cc_d = '0;
        dc_d = '0;
        rm_d = '0;
        ph_d = attr_d ? PH_VALUE : PH_TEXT;
      end
      if (fl) begin
        batch_o.r[n] = mk_res(EvError, 8'h00, fc, lw[23:0]);
        n = n + ResCntW'(1);
        tl_d = lc_d;
        ep_d = 1'b0;
        tp_d = 1'b0;
        ph_d = PH_HALT;
      end
      if (eof) begin
        lw = {24'b0, tl_d};
        batch_o.r[n] = mk_res(EvEof, 8'h00, 4'd0, lw[23:0]);
        n = n + ResCntW'(1);
        ph_d = PH_HALT;
      end
    end
    batch_o.cnt = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_TEXT;
      rs_q   <= RS_START;
      attr_q <= 1'b0;
      lc_q   <= LineOne;
      tl_q   <= LineOne;
      cc_q   <= '0;
      rm_q   <= '0;
      dc_q   <= '0;
      cm_q   <= '0;
      tk_q   <= TagSection;
      ep_q   <= 1'b0;
      tp_q   <= 1'b0;
      dm_q   <= '0;
    end else if (fire_i) begin
      ph_q   <= ph_d;
      rs_q   <= rs_d;
      attr_q <= attr_d;
      lc_q   <= lc_d;
      tl_q   <= tl_d;
      cc_q   <= cc_d;
      rm_q   <= rm_d;
      dc_q   <= dc_d;
      cm_q   <= cm_d;
      tk_q   <= tk_d;
      ep_q   <= ep_d;
      tp_q   <= tp_d;
      dm_q   <= dm_d;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/xst_out.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xst_out: result register
// holds one batch of events and hands them out one per transaction
// ----------------------------------------------------------------------------
module xst_out (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            load_i,
  input  xst_pkg::batch_t      batch_i,
  output logic                 can_load_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output xst_pkg::res_t        res_o,
  output logic                 last_o
);
  import xst_pkg::*;

  res_t [MaxRes-1:0]  res_q;
  logic [ResCntW-1:0] cnt_q;
  logic [ResIdxW-1:0] idx_q;
  logic               take;

  assign out_valid_o = (cnt_q != '0);
  assign res_o       = res_q[idx_q];
  assign last_o      = (ResCntW'(idx_q) + ResCntW'(1)) == cnt_q;
  assign take        = out_valid_o && !out_stall_i;
  assign can_load_o  = !out_valid_o || (take && last_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (can_load_o) begin
      idx_q <= '0;
      cnt_q <= load_i ? batch_i.cnt : '0;
    end else if (take) begin
      idx_q <= idx_q + ResIdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_load_o && load_i) res_q <= batch_i.r;
  end

endmodule
`default_nettype wire

// File: hw/rtl/xml_stream_tokenizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xml_stream_tokenizer: streaming xml tokenizer
// bytes of xml text in, tagged events (text, names, values, marks) out
// ----------------------------------------------------------------------------
// usage
// - input channel: in_valid_i / in_stall_o carry one byte (or end of input)
//   per transaction; an input register takes a byte in every cycle that in_stall_o is low
// - output channel: out_valid_o / out_stall_i carry one event per transaction,
//   last_of_run_o marks the final event caused by one input byte
// - path: a taken byte passes the input register, then the result register,
//   before its events leave
// - throughput: one byte per cycle while each byte makes at most one event
//   and out_stall_i is low; a byte that makes more events holds the input
//   until its last event is taken, as events leave one per cycle at most
// - a byte that makes no event shows nothing on the output channel
// - reset clears the parser to the text phase with line one and empties the
//   input and result registers
// - out_stall_i holds the current event; the input register fills and then
//   in_stall_o rises until the result register drains
// ----------------------------------------------------------------------------
module xml_stream_tokenizer #(
  parameter int unsigned LINE_BITS    = xst_pkg::LineBitsDef,
  parameter int unsigned REF_NAME_MAX = xst_pkg::RefNameMaxDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_input_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       event_kind_o,
  output logic [7:0]       out_byte_o,
  output logic [3:0]       error_code_o,
  output logic [23:0]      line_number_o,
  output logic             last_of_run_o
);
  import xst_pkg::*;

  // input register
  logic       in_vld_q;
  logic [7:0] byte_q;
  logic       eof_q;
  logic       can_load;
  logic       fire;
  batch_t     batch;
  res_t       res;

  // the step runs when the result register can take its batch
  assign fire       = in_vld_q && can_load;
  assign in_stall_o = in_vld_q && !can_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  // payload holds without reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= data_byte_i;
      eof_q  <= end_of_input_i;
    end
  end

  xst_step #(
    .LINE_BITS    (LINE_BITS),
    .REF_NAME_MAX (REF_NAME_MAX)
  ) u_step (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .data_byte_i    (byte_q),
    .end_of_input_i (eof_q),
    .batch_o        (batch)
  );

  xst_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .batch_i     (batch),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res),
    .last_o      (last_of_run_o)
  );

  assign event_kind_o  = res.kind;
  assign out_byte_o    = res.data;
  assign error_code_o  = res.err;
  assign line_number_o = res.line;

endmodule
`default_nettype wire
